[hdl/bqdf2_pkg.sv]
// ----------------------------------------------------------------------------
// bqdf2_pkg
// Shared types and constants of the direct form II biquad section: word
// widths, configuration register map with reset values, sequencer states.
// ----------------------------------------------------------------------------
package bqdf2_pkg;

    // Coefficient and gain words (Q4.f), delay line words
    localparam int COEFF_W   = 20;
    localparam int DELAY_W   = 32;

    // Configuration register map
    localparam int REG_COUNT = 7;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0  = 3'd0,
        REG_B1  = 3'd1,
        REG_B2  = 3'd2,
        REG_A1  = 3'd3,
        REG_A2  = 3'd4,
        REG_GIN = 3'd5,
        REG_GOUT = 3'd6,
        REG_NONE = 3'd7
    } reg_idx_t;

    // Register reset values
    localparam logic signed [COEFF_W-1:0] RST_B0   = 20'sd65536;
    localparam logic signed [COEFF_W-1:0] RST_B1   = 20'sd65536;
    localparam logic signed [COEFF_W-1:0] RST_B2   = 20'sd0;
    localparam logic signed [COEFF_W-1:0] RST_A1   = -20'sd64312;
    localparam logic signed [COEFF_W-1:0] RST_A2   = 20'sd0;
    localparam logic signed [COEFF_W-1:0] RST_GIN  = 20'sd612;
    localparam logic signed [COEFF_W-1:0] RST_GOUT = 20'sd65536;

    // Sequencer: one state per multiplier use plus idle, sum, v and output
    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_G0   = 11'b000_0000_0010,
        ST_A1   = 11'b000_0000_0100,
        ST_A2   = 11'b000_0000_1000,
        ST_B1   = 11'b000_0001_0000,
        ST_B2   = 11'b000_0010_0000,
        ST_B0   = 11'b000_0100_0000,
        ST_SUM  = 11'b000_1000_0000,
        ST_V    = 11'b001_0000_0000,
        ST_G1   = 11'b010_0000_0000,
        ST_OUT  = 11'b100_0000_0000
    } state_t;

endpackage

[hdl/biquad_iir_df2_filter.sv]
// An accepted input word walks the multiply schedule to m_tvalid; a new
// word is taken only in idle. One shared multiplier is used seven times
// per sample under a one-hot sequencer, plus rounding steps.
// A pending output word stalls the final step until m_tready.
// Reset (aresetn low, synchronous): delays clear, registers take their reset
// values, sequencer returns to idle and the output word is dropped.
// ----------------------------------------------------------------------------
// biquad_iir_df2_filter
// Second-order IIR section, direct form II, with input and output gain,
// fixed point with saturation of the intermediate value and the output.
// ----------------------------------------------------------------------------
module biquad_iir_df2_filter
    import bqdf2_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int COEFF_FRAC_BITS = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration write channel
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [REG_IDX_W-1:0]                      cfg_index,
    input  logic [COEFF_W-1:0]                        cfg_data,
    // input samples
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,  // sample_in
    // filtered samples
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata,  // filtered_out
    output logic [0:0]                                m_tuser   // clipped
);

    localparam int TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int DELAY_FRAC = DELAY_W - SAMPLE_WIDTH;
    localparam int ACC_W      = COEFF_W + DELAY_W + 2;
    localparam int RND_W      = ACC_W + 1;
    localparam int V_W        = RND_W - COEFF_FRAC_BITS;
    localparam int MD_W       = (V_W > DELAY_W) ? V_W : DELAY_W;
    localparam int PROD_W     = COEFF_W + MD_W;
    localparam int FS         = COEFF_FRAC_BITS + DELAY_FRAC;
    localparam int Y_W        = ((PROD_W > FS) ? PROD_W : FS) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COEFF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [COEFF_W-1:0] gin_reg, gout_reg;

    // no writes taken while in reset
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg   <= RST_B0;
            b1_reg   <= RST_B1;
            b2_reg   <= RST_B2;
            a1_reg   <= RST_A1;
            a2_reg   <= RST_A2;
            gin_reg  <= RST_GIN;
            gout_reg <= RST_GOUT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_B0:   b0_reg   <= cfg_data;
                REG_B1:   b1_reg   <= cfg_data;
                REG_B2:   b2_reg   <= cfg_data;
                REG_A1:   a1_reg   <= cfg_data;
                REG_A2:   a2_reg   <= cfg_data;
                REG_GIN:  gin_reg  <= cfg_data;
                REG_GOUT: gout_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t                          state_reg, state_next;
    logic signed [SAMPLE_WIDTH-1:0]  sample_reg;
    logic signed [DELAY_W-1:0]       delay_one_reg, delay_two_reg;
    logic signed [DELAY_W-1:0]       w_reg, w_next;
    logic signed [V_W-1:0]           v_reg;
    logic signed [ACC_W-1:0]         acc_reg, acc_next;
    logic                            clip_reg, w_clip;
    logic                            m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]  y_reg, y_next;
    logic                            m_clip_reg, y_clip;
    logic                            in_accept, out_load;

    logic                            mul_en;
    logic signed [COEFF_W-1:0]       mul_coeff;
    logic signed [MD_W-1:0]          mul_data;
    logic signed [PROD_W-1:0]        prod;

    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // Next state: a fixed walk through the multiply schedule
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_accept) state_next = ST_G0;
            ST_G0:   state_next = ST_A1;
            ST_A1:   state_next = ST_A2;
            ST_A2:   state_next = ST_B1;
            ST_B1:   state_next = ST_B2;
            ST_B2:   state_next = ST_B0;
            ST_B0:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_V;
            ST_V:    state_next = ST_G1;
            ST_G1:   state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Multiplier operand select
    always_comb begin
        mul_en    = 1'b1;
        mul_coeff = gin_reg;
        mul_data  = MD_W'(DELAY_W'(sample_reg) <<< DELAY_FRAC);
        unique case (state_reg)
            ST_G0: begin
                mul_coeff = gin_reg;
                mul_data  = MD_W'(DELAY_W'(sample_reg) <<< DELAY_FRAC);
            end
            ST_A1: begin
                mul_coeff = a1_reg;
                mul_data  = MD_W'(delay_one_reg);
            end
            ST_A2: begin
                mul_coeff = a2_reg;
                mul_data  = MD_W'(delay_two_reg);
            end
            ST_B1: begin
                mul_coeff = b1_reg;
                mul_data  = MD_W'(delay_one_reg);
            end
            ST_B2: begin
                mul_coeff = b2_reg;
                mul_data  = MD_W'(delay_two_reg);
            end
            ST_B0: begin
                mul_coeff = b0_reg;
                mul_data  = MD_W'(w_reg);
            end
            ST_G1: begin
                mul_coeff = gout_reg;
                mul_data  = MD_W'(v_reg);
            end
            default: mul_en = 1'b0;
        endcase
    end

    bqdf2_mul #(
        .DATA_W (MD_W)
    ) u_mul (
        .aclk  (aclk),
        .en    (mul_en),
        .coeff (mul_coeff),
        .data  (mul_data),
        .prod  (prod)
    );

    // Round the accumulator by the coefficient fraction (ties upward)
    logic signed [RND_W-1:0] acc_rnd;
    logic signed [V_W-1:0]   v_full;
    logic signed [MD_W-1:0]  v_ext;
    logic [MD_W-DELAY_W:0]   w_top;

    assign acc_rnd = (RND_W'(acc_reg) + (RND_W'(1) <<< (COEFF_FRAC_BITS - 1)))
                     >>> COEFF_FRAC_BITS;
    assign v_full  = V_W'(acc_rnd);
    assign v_ext   = MD_W'(v_full);
    assign w_top   = v_ext[MD_W-1:DELAY_W-1];

    // Intermediate value saturated to the delay word
    always_comb begin
        w_clip = !((&w_top) || !(|w_top));
        if (!w_clip) begin
            w_next = DELAY_W'(v_ext);
        end else if (v_ext[MD_W-1]) begin
            w_next = {1'b1, {(DELAY_W-1){1'b0}}};
        end else begin
            w_next = {1'b0, {(DELAY_W-1){1'b1}}};
        end
    end

    // Output rounding and saturation to the sample width
    logic signed [Y_W-1:0]          y_rnd;
    logic [Y_W-SAMPLE_WIDTH:0]      y_top;

    assign y_rnd = (Y_W'(prod) + (Y_W'(1) <<< (FS - 1))) >>> FS;
    assign y_top = y_rnd[Y_W-1:SAMPLE_WIDTH-1];

    always_comb begin
        y_clip = !((&y_top) || !(|y_top));
        if (!y_clip) begin
            y_next = SAMPLE_WIDTH'(y_rnd);
        end else if (y_rnd[Y_W-1]) begin
            y_next = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            y_next = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    // Accumulator: feedback sum, then feedforward sum
    always_comb begin
        acc_next = acc_reg;
        unique case (state_reg)
            ST_A1:   acc_next = ACC_W'(prod);
            ST_A2:   acc_next = acc_reg - ACC_W'(prod);
            ST_B1:   acc_next = acc_reg - ACC_W'(prod);
            ST_B2:   acc_next = ACC_W'(prod);
            ST_B0:   acc_next = acc_reg + ACC_W'(prod);
            ST_SUM:  acc_next = acc_reg + ACC_W'(prod);
            default: acc_next = acc_reg;
        endcase
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (in_accept) begin
            sample_reg <= SAMPLE_WIDTH'(s_tdata);
        end
        if (state_reg == ST_B2) begin
            w_reg    <= w_next;
            clip_reg <= w_clip;
        end
        if (state_reg == ST_V) begin
            v_reg <= v_full;
        end
        if (out_load) begin
            y_reg      <= y_next;
            m_clip_reg <= clip_reg | y_clip;
        end
    end

    // Control state, delay line and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                delay_two_reg <= delay_one_reg;
                delay_one_reg <= w_reg;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(unsigned'(y_reg));
    assign m_tuser  = m_clip_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts : assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == ST_G0)
        else $error("accepted word did not start the multiply schedule");

    a_valid_from_out : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("output word appeared outside the final step");

    a_delay_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !out_load |=> $stable(delay_one_reg) && $stable(delay_two_reg))
        else $error("delay line moved without an output word");

    a_out_loads : assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && state_reg == ST_IDLE)
        else $error("final step did not present a word");

endmodule

[hdl/bqdf2_mul.sv]
// ----------------------------------------------------------------------------
// bqdf2_mul
// Shared signed multiplier: coefficient word times data word, product
// registered. One product per enabled cycle.
// ----------------------------------------------------------------------------
module bqdf2_mul
    import bqdf2_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [COEFF_W-1:0]         coeff,
    input  logic signed [DATA_W-1:0]          data,
    output logic signed [COEFF_W+DATA_W-1:0]  prod
);

    logic signed [COEFF_W+DATA_W-1:0] prod_reg;
    logic signed [COEFF_W+DATA_W-1:0] prod_next;

    assign prod_next = (COEFF_W+DATA_W)'(coeff) * (COEFF_W+DATA_W)'(data);

    // Product register
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
